// ----- sv/jse_pkg.sv -----
package jse_pkg;

  // Default depth of the queue between the classifier and the expander.
  localparam int unsigned FIFO_DEPTH = 4;

  // Kinds of queued work.
  localparam logic [1:0] KIND_PLAIN = 2'd0;  // byte passes through
  localparam logic [1:0] KIND_SHORT = 2'd1;  // backslash plus one letter
  localparam logic [1:0] KIND_UNI   = 2'd2;  // \u00 plus two hex digits
  localparam logic [1:0] KIND_END   = 2'd3;  // closing quote

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CTRL_MAX  = 8'h1F;

  // One classified input item as it sits in the queue.
  typedef struct packed {
    logic       open_q;  // an opening quote goes out first
    logic [1:0] kind;
    logic [7:0] data;    // raw byte, or the escape letter for KIND_SHORT
  } desc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'h0, v};
    end else begin
      r = 8'h57 + {4'h0, v};
    end
    return r;
  endfunction

  // Letter of the two-byte escape, zero where the byte has none.
  function automatic logic [7:0] short_letter(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h08:     r = 8'h62;
      8'h0A:     r = 8'h6E;
      8'h0C:     r = 8'h66;
      8'h0D:     r = 8'h72;
      8'h09:     r = 8'h74;
      CH_QUOTE:  r = CH_QUOTE;
      CH_BSLASH: r = CH_BSLASH;
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

  // Output bytes of a kind, not counting the opening quote.
  function automatic logic [2:0] body_len(input logic [1:0] kind);
    logic [2:0] r;
    case (kind)
      KIND_PLAIN: r = 3'd1;
      KIND_SHORT: r = 3'd2;
      KIND_UNI:   r = 3'd6;
      KIND_END:   r = 3'd1;
      default:    r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/json_string_escaper_top.sv -----
// JSON string escaper. Bytes of a string arrive on the in_ channel, one per
// transfer, with in_tuser low; a transfer with in_tuser high ends the string
// and its in_tdata is ignored. The out_ channel carries the quoted, escaped
// text one byte per transfer; out_tlast marks the final byte that belongs to
// one input transfer. An opening quote precedes the first byte of a string,
// control characters become two-byte or six-byte escapes, and an end item
// emits the closing quote (two quotes for an empty string).
// An accepted input transfer is written into the queue, and the expander then
// loads the first output byte of its item into its output register.
// Throughput: one output byte per cycle while out_tready is high, set by the
// single output register of the expander; plain bytes flow at one item per
// cycle, while an item of N bytes (up to 7) holds the expander until its last
// byte is out. A queue of FIFO_DEPTH entries between the classifier and the
// expander absorbs such bursts; in_tready drops only when that queue is full.
// Reset (rst_n low, synchronous) empties the queue, drops out_tvalid and
// marks the stream as outside a string. When the receiver holds out_tready
// low the output byte stays put and the queue fills, then input stalls.
module json_string_escaper_top #(
  parameter int unsigned FIFO_DEPTH = jse_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic       in_tuser,   // [0] req_type: 0 string byte, 1 end of string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // last_of_run
);

  jse_pkg::desc_t q_wdata;
  jse_pkg::desc_t q_rdata;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  // Classifier: tracks whether a string is open and tags each item.
  jse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // Work queue that decouples input acceptance from output expansion.
  jse_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // Expander: walks the bytes of the head item into the output register.
  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- sv/jse_front.sv -----
module jse_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,
  input  logic [7:0]        in_tdata,
  input  logic              q_full,
  output logic              q_push,
  output jse_pkg::desc_t    q_wdata
);

  logic       inside_r;
  logic       inside_nxt;
  logic [7:0] letter;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign letter    = jse_pkg::short_letter(in_tdata);

  always_comb begin
    q_wdata.open_q = !inside_r;
    q_wdata.data   = in_tdata;
    if (in_tuser) begin
      q_wdata.kind = jse_pkg::KIND_END;
    end else if (letter != 8'h00) begin
      q_wdata.kind = jse_pkg::KIND_SHORT;
      q_wdata.data = letter;
    end else if (in_tdata <= jse_pkg::CTRL_MAX) begin
      q_wdata.kind = jse_pkg::KIND_UNI;
    end else begin
      q_wdata.kind = jse_pkg::KIND_PLAIN;
    end
  end

  // An end item closes the string, any byte opens or continues one.
  always_comb begin
    inside_nxt = inside_r;
    if (q_push) begin
      inside_nxt = !in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
    end
  end

endmodule

// ----- sv/jse_fifo.sv -----
module jse_fifo #(
  parameter int unsigned DEPTH = jse_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jse_pkg::desc_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output jse_pkg::desc_t rdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jse_pkg::desc_t slot_r [DEPTH];
  logic [AW-1:0]  wptr_r, wptr_nxt;
  logic [AW-1:0]  rptr_r, rptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = slot_r[rptr_r];

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wptr_nxt  = push ? ptr_inc(wptr_r) : wptr_r;
    rptr_nxt  = pop  ? ptr_inc(rptr_r) : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

endmodule

// ----- sv/jse_back.sv -----
module jse_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  jse_pkg::desc_t q_rdata,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);

  logic [2:0] idx_r, idx_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic [7:0] out_tdata_r;
  logic       out_tlast_r;

  logic [2:0] len;
  logic [2:0] pos;
  logic [7:0] byte_sel;
  logic       is_last;
  logic       load;

  assign len     = {2'b00, q_rdata.open_q} + jse_pkg::body_len(q_rdata.kind);
  assign pos     = idx_r - {2'b00, q_rdata.open_q};
  assign is_last = (idx_r == len - 3'd1);
  assign load    = !q_empty && (!out_tvalid_r || out_tready);
  assign q_pop   = load && is_last;

  always_comb begin
    byte_sel = q_rdata.data;
    if (q_rdata.open_q && idx_r == 3'd0) begin
      byte_sel = jse_pkg::CH_QUOTE;
    end else begin
      case (q_rdata.kind)
        jse_pkg::KIND_PLAIN: byte_sel = q_rdata.data;
        jse_pkg::KIND_SHORT: byte_sel = (pos == 3'd0) ? jse_pkg::CH_BSLASH : q_rdata.data;
        jse_pkg::KIND_END:   byte_sel = jse_pkg::CH_QUOTE;
        jse_pkg::KIND_UNI: begin
          case (pos)
            3'd0:    byte_sel = jse_pkg::CH_BSLASH;
            3'd1:    byte_sel = jse_pkg::CH_U;
            3'd2:    byte_sel = jse_pkg::CH_ZERO;
            3'd3:    byte_sel = jse_pkg::CH_ZERO;
            3'd4:    byte_sel = jse_pkg::hex_char(q_rdata.data[7:4]);
            default: byte_sel = jse_pkg::hex_char(q_rdata.data[3:0]);
          endcase
        end
        default: byte_sel = q_rdata.data;
      endcase
    end
  end

  always_comb begin
    idx_nxt        = idx_r;
    out_tvalid_nxt = out_tvalid_r;
    if (load) begin
      idx_nxt        = is_last ? 3'd0 : idx_r + 3'd1;
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= 3'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      idx_r        <= idx_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= byte_sel;
      out_tlast_r <= is_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> idx_r < len)
    else $error("expansion index past the end of its item");

  a_pop_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> idx_r == 3'd0)
    else $error("index not rewound after the last byte of an item");

  a_open_quote: assert property (@(posedge clk) disable iff (!rst_n)
    load && q_rdata.open_q && idx_r == 3'd0 |=> out_tdata_r == jse_pkg::CH_QUOTE)
    else $error("opening quote missing");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for json_string_escaper_top. Each test task below feeds
// string bytes and end items through the in_ channel. Every accepted transfer
// goes through a predictor that works out the quoted, escaped JSON text.
// A monitor on the out_ channel checks each output transfer, in order,
// against that expected text.
module tb;

  // Meaning of in_tuser.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // The slowest legal run stays far below this: about 220 items, each with up to
  // seven output bytes, and each byte waiting out the longest receiver stall.
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned MAX_REPORTS = 10;

  // One expected output transfer.
  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } json_char_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] char_byte
  logic       in_tuser;   // [0] req_type
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;  // last_of_run

  // Expected JSON text that has not yet appeared on the out_ channel.
  json_char_t  pending_text[$];
  // The bench's own copy of the opening-quote state.
  logic        quote_open;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned items_sent;
  // When set, the sender or the receiver never idles.
  bit          tx_steady;
  bit          rx_steady;
  int unsigned rx_left;

  json_string_escaper_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle stretch lengths. Most of them are short, and a few are long enough
  // to fill the queue inside the block.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return $urandom_range(1, 3);
    end else if (r < 90) begin
      return $urandom_range(4, 8);
    end
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v > 4'd9) begin
      return "a" + 8'(v - 4'd10);
    end
    return "0" + 8'(v);
  endfunction

  // Appends the JSON text for one accepted item to pending_text. The last
  // byte of each item carries the tlast flag.
  task automatic escape_into_text(input logic req, input logic [7:0] ch);
    logic [7:0] seq[$];
    logic [7:0] letter;
    begin
      letter = 8'h00;
      if (req == REQ_END) begin
        // An end item with no string open closes an empty string "".
        if (!quote_open) begin
          seq.push_back(jse_pkg::CH_QUOTE);
        end
        seq.push_back(jse_pkg::CH_QUOTE);
        quote_open = 1'b0;
      end else begin
        if (!quote_open) begin
          seq.push_back(jse_pkg::CH_QUOTE);
          quote_open = 1'b1;
        end
        case (ch)
          8'h08:              letter = "b";
          8'h09:              letter = "t";
          8'h0A:              letter = "n";
          8'h0C:              letter = "f";
          8'h0D:              letter = "r";
          jse_pkg::CH_QUOTE:  letter = jse_pkg::CH_QUOTE;
          jse_pkg::CH_BSLASH: letter = jse_pkg::CH_BSLASH;
          default:            letter = 8'h00;
        endcase
        if (letter != 8'h00) begin
          seq.push_back(jse_pkg::CH_BSLASH);
          seq.push_back(letter);
        end else if (ch <= jse_pkg::CTRL_MAX) begin
          // The remaining control characters use the \u00XX form.
          seq.push_back(jse_pkg::CH_BSLASH);
          seq.push_back(jse_pkg::CH_U);
          seq.push_back(jse_pkg::CH_ZERO);
          seq.push_back(jse_pkg::CH_ZERO);
          seq.push_back(hex_digit(ch[7:4]));
          seq.push_back(hex_digit(ch[3:0]));
        end else begin
          seq.push_back(ch);
        end
      end
      foreach (seq[i]) begin
        pending_text.push_back('{text: seq[i], last: (i == seq.size() - 1)});
      end
    end
  endtask

  // Sends one item. The task starts just after a rising edge. It drives at
  // falling edges, and it waits for the transfer at rising edges. A gap lowers
  // in_tvalid at one falling edge, and the valid is raised again at a later one.
  task automatic send_item(input logic req, input logic [7:0] ch);
    int unsigned gap;
    begin
      gap = 0;
      if (!tx_steady && $urandom_range(0, 2) == 0) begin
        gap = idle_len();
      end
      @(negedge clk);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser  <= req;
      in_tdata  <= ch;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      escape_into_text(req, ch);
      items_sent++;
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Waits until every expected byte has arrived.
  task automatic wait_drain();
    while (pending_text.size() != 0) @(posedge clk);
  endtask

  // String content biased toward the bytes that expand.
  function automatic logic [7:0] pick_string_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: return 8'($urandom_range(0, 31));
      3:       return ($urandom_range(0, 1) == 0) ? jse_pkg::CH_QUOTE : jse_pkg::CH_BSLASH;
      4:       return 8'($urandom_range(8'h80, 8'hFF));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Empty strings, the first byte of a string, every escape form, the edges of
  // the control range, and the bytes that pass through unchanged.
  task automatic test_directed();
    logic [7:0] picks[$];
    begin
      picks = '{8'h00, 8'h1F, 8'h08, 8'h0A, 8'h0C, 8'h0D, 8'h09, jse_pkg::CH_QUOTE,
                jse_pkg::CH_BSLASH, 8'h7F, 8'h80, 8'hFF, 8'h20, 8'h10, 8'h1A};
      send_item(REQ_END, 8'h00);
      send_item(REQ_END, 8'hFF);
      send_item(REQ_BYTE, 8'h41);
      foreach (picks[i]) begin
        send_item(REQ_BYTE, picks[i]);
      end
      // The data of an end item is ignored.
      send_item(REQ_END, 8'h0A);
      // This first byte needs the quote and a six-byte escape, seven bytes in all.
      send_item(REQ_BYTE, 8'h01);
      send_item(REQ_END, 8'h5C);
    end
  endtask

  // Well-formed strings with random content and random lengths. An empty
  // string shows up now and then.
  task automatic test_random_strings(input int unsigned quota);
    int unsigned target;
    int unsigned len;
    begin
      target = items_sent + quota;
      while (items_sent < target) begin
        len = $urandom_range(0, 12);
        repeat (len) send_item(REQ_BYTE, pick_string_byte());
        send_item(REQ_END, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // The sender holds off in the middle of a string until all output has
  // drained. The string then carries on from where it stopped.
  task automatic test_drain_pause();
    begin
      repeat (6) send_item(REQ_BYTE, pick_string_byte());
      stop_sending();
      wait_drain();
      repeat (3) send_item(REQ_BYTE, pick_string_byte());
      send_item(REQ_END, 8'($urandom_range(0, 255)));
    end
  endtask

  // Unstructured items: repeated ends and stray bytes, with both fields
  // uniform over their full range.
  task automatic test_noise(input int unsigned count);
    begin
      repeat (count) begin
        send_item(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Back-to-back transfers with a receiver that never stalls. The escapes
  // among them can still fill the queue and push back on the sender.
  task automatic test_full_rate();
    begin
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      repeat (20) begin
        send_item(REQ_BYTE, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 31))
                                                         : 8'($urandom_range(32, 255)));
      end
      send_item(REQ_END, 8'h00);
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end
  endtask

  // Receiver. Ready stretches alternate with stalls of random length. While
  // rx_steady is set, the receiver stays ready.
  always @(negedge clk) begin
    if (rx_steady) begin
      out_tready <= 1'b1;
      rx_left = 0;
    end else if (rx_left > 0) begin
      rx_left = rx_left - 1;
    end else if (!out_tready) begin
      out_tready <= 1'b1;
      rx_left = $urandom_range(0, 15);
    end else begin
      out_tready <= 1'b0;
      rx_left = idle_len() - 1;
    end
  end

  // Output monitor. Each transfer is compared with the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_text.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected output transfer: byte %h last %0b", out_tdata, out_tlast);
        end
      end else begin
        if (out_tdata !== pending_text[0].text || out_tlast !== pending_text[0].last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("output mismatch: expected byte %h last %0b, got byte %h last %0b",
                     pending_text[0].text, pending_text[0].last, out_tdata, out_tlast);
          end
        end
        void'(pending_text.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL json_string_escaper_top");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tuser   = REQ_BYTE;
    out_tready = 1'b0;
    quote_open = 1'b0;
    mismatches = 0;
    cycles     = 0;
    items_sent = 0;
    tx_steady  = 1'b0;
    rx_steady  = 1'b0;
    rx_left    = 0;
    // Reset is held low and released at a falling edge.
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_strings(80);
    test_drain_pause();
    test_full_rate();
    test_noise(45);
    test_random_strings(25);
    stop_sending();

    wait_drain();
    // Extra cycles so that any spurious trailing transfer is caught.
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS json_string_escaper_top");
    end else begin
      $display("FAIL json_string_escaper_top");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/jse_pkg.sv
sv/jse_front.sv
sv/jse_fifo.sv
sv/jse_back.sv
sv/json_string_escaper_top.sv
tb/sv/tb.sv
